[src/q2r_pkg.sv]
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared constants, types and helpers of the quaternion to rotation matrix
// unit.
// ----------------------------------------------------------------------------
package q2r_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int DEN_W     = PROD_W + 1;
    localparam int QUO_W     = FRAC_BITS + 2;
    localparam int SAT_W     = QUO_W + 2;
    localparam int ENTRIES   = 9;

    typedef struct packed {
        logic [ENTRIES-1:0]             neg;
        logic [ENTRIES-1:0][DEN_W-1:0]  rem;
        logic [ENTRIES-1:0][QUO_W-1:0]  quo;
        logic [DEN_W-1:0]               den;
        logic                           deg;
    } div_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sd32767);
        lo = SAT_W'(-32'sd32768);
        if (v > hi) begin
            sat_out = hi[OUT_W-1:0];
        end else if (v < lo) begin
            sat_out = lo[OUT_W-1:0];
        end else begin
            sat_out = v[OUT_W-1:0];
        end
    endfunction

    // round half away: q = (t + 1) / 2, then apply sign and saturate
    function automatic logic [OUT_W-1:0] finish(input logic [QUO_W-1:0] t, input logic neg);
        logic [QUO_W:0]          inc;
        logic signed [SAT_W-1:0] mag;
        inc = {1'b0, t} + {{QUO_W{1'b0}}, 1'b1};
        mag = $signed({2'b00, inc[QUO_W:1]});
        finish = sat_out(neg ? -mag : mag);
    endfunction

    function automatic logic [OUT_W-1:0] unit_val();
        logic signed [SAT_W-1:0] one;
        one = SAT_W'(1) <<< FRAC_BITS;
        unit_val = sat_out(one);
    endfunction

endpackage

[src/quaternion_to_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Converts a Q1.14 quaternion of any length into its normalized 3x3 rotation
// matrix in Q1.FRAC_BITS, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_valid/s_ready carries qx, qy, qz, qw. Output beat on
//   m_valid/m_ready carries m00..m22 and degenerate.
//   One beat is taken per cycle while the output is not stalled. The stages
//   are the input register, products, sums, magnitudes, one restoring
//   divider step per stage for each of the FRAC_BITS + 2 quotient bits,
//   and the output register.
//   All nine entries share the squared norm as divisor; each divider lane
//   resolves one quotient bit per stage with a 34-bit compare and subtract.
//   An all-zero quaternion gives the identity matrix with degenerate set.
//   Reset clears all stage valid bits; no data is held over.
//   When the receiver stalls, the output holds and each stage advances only
//   into an empty slot, so bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit
    import q2r_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_qx,
    input  logic signed [IN_W-1:0]  s_qy,
    input  logic signed [IN_W-1:0]  s_qz,
    input  logic signed [IN_W-1:0]  s_qw,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_m00,
    output logic signed [OUT_W-1:0] m_m01,
    output logic signed [OUT_W-1:0] m_m02,
    output logic signed [OUT_W-1:0] m_m10,
    output logic signed [OUT_W-1:0] m_m11,
    output logic signed [OUT_W-1:0] m_m12,
    output logic signed [OUT_W-1:0] m_m20,
    output logic signed [OUT_W-1:0] m_m21,
    output logic signed [OUT_W-1:0] m_m22,
    output logic                    m_degenerate
);

    localparam int NST = QUO_W + 5;
    localparam int DIV0 = 4;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    logic signed [IN_W-1:0] x_reg, y_reg, z_reg, w_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [NUM_W-1:0] num_reg [ENTRIES];
    logic [DEN_W-1:0] n_reg;
    div_t abs_reg;
    div_t div_reg [QUO_W];
    div_t div_next [QUO_W];
    logic [OUT_W-1:0] m_reg [ENTRIES];
    logic deg_reg;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = NST - 1; k >= 1; k--) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg <= s_qx;
            y_reg <= s_qy;
            z_reg <= s_qz;
            w_reg <= s_qw;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            ww_reg <= w_reg * w_reg;
            xy_reg <= x_reg * y_reg;
            xz_reg <= x_reg * z_reg;
            yz_reg <= y_reg * z_reg;
            wx_reg <= w_reg * x_reg;
            wy_reg <= w_reg * y_reg;
            wz_reg <= w_reg * z_reg;
        end
    end

    logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
    assign exx = NUM_W'(xx_reg);
    assign eyy = NUM_W'(yy_reg);
    assign ezz = NUM_W'(zz_reg);
    assign eww = NUM_W'(ww_reg);
    assign exy = NUM_W'(xy_reg);
    assign exz = NUM_W'(xz_reg);
    assign eyz = NUM_W'(yz_reg);
    assign ewx = NUM_W'(wx_reg);
    assign ewy = NUM_W'(wy_reg);
    assign ewz = NUM_W'(wz_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            num_reg[0] <= exx + eww - eyy - ezz;
            num_reg[1] <= (exy + ewz) <<< 1;
            num_reg[2] <= (exz - ewy) <<< 1;
            num_reg[3] <= (exy - ewz) <<< 1;
            num_reg[4] <= eyy + eww - exx - ezz;
            num_reg[5] <= (eyz + ewx) <<< 1;
            num_reg[6] <= (exz + ewy) <<< 1;
            num_reg[7] <= (eyz - ewx) <<< 1;
            num_reg[8] <= ezz + eww - exx - eyy;
            n_reg <= {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg} + {1'b0, ww_reg};
        end
    end

    div_t abs_next;
    logic [NUM_W-1:0] absv [ENTRIES];
    always_comb begin
        abs_next.den = n_reg;
        abs_next.deg = (n_reg == '0);
        for (int i = 0; i < ENTRIES; i++) begin
            abs_next.neg[i] = num_reg[i][NUM_W-1];
            absv[i] = num_reg[i][NUM_W-1] ? NUM_W'(-num_reg[i]) : NUM_W'(num_reg[i]);
            abs_next.rem[i] = absv[i][DEN_W-1:0];
            abs_next.quo[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            abs_reg <= abs_next;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        div_t src;
        logic [DEN_W:0] cmp [ENTRIES];
        logic [DEN_W:0] dif [ENTRIES];
        if (j == 0) begin : g_first
            assign src = abs_reg;
        end else begin : g_rest
            assign src = div_reg[j-1];
        end
        always_comb begin
            div_next[j] = src;
            for (int i = 0; i < ENTRIES; i++) begin
                cmp[i] = (j == 0) ? {1'b0, src.rem[i]} : {src.rem[i], 1'b0};
                dif[i] = cmp[i] - {1'b0, src.den};
                if (cmp[i] >= {1'b0, src.den}) begin
                    div_next[j].rem[i] = dif[i][DEN_W-1:0];
                    div_next[j].quo[i] = {src.quo[i][QUO_W-2:0], 1'b1};
                end else begin
                    div_next[j].rem[i] = cmp[i][DEN_W-1:0];
                    div_next[j].quo[i] = {src.quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en[DIV0 + j]) begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            deg_reg <= div_reg[QUO_W-1].deg;
            for (int i = 0; i < ENTRIES; i++) begin
                if (div_reg[QUO_W-1].deg) begin
                    m_reg[i] <= (i == 0 || i == 4 || i == 8) ? unit_val() : '0;
                end else begin
                    m_reg[i] <= finish(div_reg[QUO_W-1].quo[i], div_reg[QUO_W-1].neg[i]);
                end
            end
        end
    end

    assign m_m00 = m_reg[0];
    assign m_m01 = m_reg[1];
    assign m_m02 = m_reg[2];
    assign m_m10 = m_reg[3];
    assign m_m11 = m_reg[4];
    assign m_m12 = m_reg[5];
    assign m_m20 = m_reg[6];
    assign m_m21 = m_reg[7];
    assign m_m22 = m_reg[8];
    assign m_degenerate = deg_reg;

endmodule
